// ===== design/tftp_transfer_session_assert.svh =====
// ----------------------------------------------------------------------------
// tftp_transfer_session_assert.svh
// Assertion macros for the TFTP transfer session RTL.
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_SESSION_ASSERT_SVH
`define TFTP_TRANSFER_SESSION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tts assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tts assertion failed");

`endif

// ===== design/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants of the TFTP transfer session.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int LEN_W   = 10;
  localparam int BLK_W   = 16;
  localparam int OP_W    = 16;
  localparam int RETX_W  = 4;
  localparam int PEER_W  = 4;
  localparam int TOTAL_W = 32;

  localparam logic [LEN_W-1:0]  BLOCK_BYTES    = LEN_W'(512);
  localparam logic [LEN_W-1:0]  HDR_BYTES      = LEN_W'(4);
  localparam logic [PEER_W-1:0] PEER_CODE_MAX  = PEER_W'(8);
  localparam logic [RETX_W-1:0] MAX_RETX_RESET = RETX_W'(2);

  localparam logic [OP_W-1:0] OP_DATA  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_ACK   = OP_W'(4);
  localparam logic [OP_W-1:0] OP_ERROR = OP_W'(5);

  typedef enum logic [1:0] {
    FN_START_READ  = 2'd0,
    FN_START_WRITE = 2'd1,
    FN_TIMEOUT     = 2'd2,
    FN_PACKET      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_DATA = 2'd1,
    SEND_ACK  = 2'd2
  } send_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_FINISHED = 2'd2,
    ST_FAILED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RSN_NONE    = 3'd0,
    RSN_RETRIES = 3'd1,
    RSN_SHORT   = 3'd2,
    RSN_PEER    = 3'd3,
    RSN_OPCODE  = 3'd4
  } reason_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_DONE  = 3'd3,
    MODE_FAIL  = 3'd4
  } mode_t;

  typedef struct packed {
    func_t              func;
    logic [LEN_W-1:0]   packet_length;
    logic [OP_W-1:0]    packet_opcode;
    logic [BLK_W-1:0]   packet_block;
    logic [LEN_W-1:0]   file_bytes;
  } in_item_t;

  typedef struct packed {
    send_kind_t         send_kind;
    logic [BLK_W-1:0]   send_block;
    logic [LEN_W-1:0]   send_length;
    logic [LEN_W-1:0]   commit_bytes;
    status_t            session_status;
    reason_t            failure_reason;
    logic [PEER_W-1:0]  peer_error;
    logic [TOTAL_W-1:0] bytes_done;
  } out_item_t;

endpackage

// ===== design/tts_engine.sv =====
// ----------------------------------------------------------------------------
// tts_engine
// Session state and the single-pass event step of the transfer session.
// ----------------------------------------------------------------------------
module tts_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  tts_pkg::in_item_t          item,
  input  logic [tts_pkg::RETX_W-1:0] max_retx,
  output tts_pkg::out_item_t         result
);
  import tts_pkg::*;

  mode_t              mode_r,   mode_nxt;
  logic [BLK_W-1:0]   exp_r,    exp_nxt;
  logic [LEN_W-1:0]   blen_r,   blen_nxt;
  logic [RETX_W-1:0]  retry_r,  retry_nxt;
  logic [TOTAL_W-1:0] total_r,  total_nxt;
  reason_t            reason_r, reason_nxt;
  logic [PEER_W-1:0]  peer_r,   peer_nxt;

  function automatic logic [LEN_W-1:0] clamp_block(input logic [LEN_W-1:0] n);
    clamp_block = (n > BLOCK_BYTES) ? BLOCK_BYTES : n;
  endfunction

  // shared decode
  logic              active, tmo, pkt, retry_out, short_pkt, op_err;
  logic              ack_ok, data_ok, match, last_read, last_write;
  logic [LEN_W-1:0]  fb_clamped, payload;
  logic [PEER_W-1:0] peer_clamped;

  always_comb begin
    active       = (mode_r == MODE_READ) || (mode_r == MODE_WRITE);
    tmo          = (item.func == FN_TIMEOUT) && active;
    pkt          = (item.func == FN_PACKET) && active;
    retry_out    = (retry_r >= max_retx);
    short_pkt    = (item.packet_length < HDR_BYTES);
    op_err       = (item.packet_opcode == OP_ERROR);
    ack_ok       = (mode_r == MODE_READ) && (item.packet_opcode == OP_ACK);
    data_ok      = (mode_r == MODE_WRITE) && (item.packet_opcode == OP_DATA);
    match        = (item.packet_block == exp_r);
    last_read    = (blen_r < BLOCK_BYTES);
    fb_clamped   = clamp_block(item.file_bytes);
    payload      = clamp_block(item.packet_length - HDR_BYTES);
    last_write   = (payload < BLOCK_BYTES);
    peer_clamped = (item.packet_block > BLK_W'(PEER_CODE_MAX)) ? PEER_CODE_MAX
                                                               : item.packet_block[PEER_W-1:0];
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    exp_nxt    = exp_r;
    blen_nxt   = blen_r;
    retry_nxt  = retry_r;
    total_nxt  = total_r;
    reason_nxt = reason_r;
    peer_nxt   = peer_r;
    if ((item.func == FN_START_READ) || (item.func == FN_START_WRITE)) begin
      exp_nxt    = BLK_W'(1);
      retry_nxt  = '0;
      total_nxt  = '0;
      reason_nxt = RSN_NONE;
      peer_nxt   = '0;
      if (item.func == FN_START_READ) begin
        mode_nxt = MODE_READ;
        blen_nxt = fb_clamped;
      end else begin
        mode_nxt = MODE_WRITE;
        blen_nxt = '0;
      end
    end else if (tmo) begin
      if (retry_out) begin
        mode_nxt   = MODE_FAIL;
        reason_nxt = RSN_RETRIES;
        peer_nxt   = '0;
      end else begin
        retry_nxt = retry_r + RETX_W'(1);
      end
    end else if (pkt) begin
      if (short_pkt) begin
        mode_nxt   = MODE_FAIL;
        reason_nxt = RSN_SHORT;
        peer_nxt   = '0;
      end else if (op_err) begin
        mode_nxt   = MODE_FAIL;
        reason_nxt = RSN_PEER;
        peer_nxt   = peer_clamped;
      end else if (ack_ok) begin
        if (match) begin
          total_nxt = total_r + TOTAL_W'(blen_r);
          if (last_read) begin
            mode_nxt = MODE_DONE;
          end else begin
            exp_nxt   = exp_r + BLK_W'(1);
            blen_nxt  = fb_clamped;
            retry_nxt = '0;
          end
        end
      end else if (data_ok) begin
        if (match) begin
          exp_nxt   = exp_r + BLK_W'(1);
          retry_nxt = '0;
          total_nxt = total_r + TOTAL_W'(payload);
          if (last_write) begin
            mode_nxt = MODE_DONE;
          end
        end
      end else begin
        mode_nxt   = MODE_FAIL;
        reason_nxt = RSN_OPCODE;
        peer_nxt   = '0;
      end
    end
  end

  // result
  always_comb begin
    result              = '0;
    result.send_kind    = SEND_NONE;
    if (item.func == FN_START_READ) begin
      result.send_kind   = SEND_DATA;
      result.send_block  = BLK_W'(1);
      result.send_length = fb_clamped;
    end else if (item.func == FN_START_WRITE) begin
      result.send_kind   = SEND_ACK;
      result.send_block  = '0;
    end else if (tmo && !retry_out) begin
      if (mode_r == MODE_READ) begin
        result.send_kind   = SEND_DATA;
        result.send_block  = exp_r;
        result.send_length = blen_r;
      end else begin
        result.send_kind   = SEND_ACK;
        result.send_block  = exp_r - BLK_W'(1);
      end
    end else if (pkt && !short_pkt && !op_err && match) begin
      if (ack_ok && !last_read) begin
        result.send_kind   = SEND_DATA;
        result.send_block  = exp_r + BLK_W'(1);
        result.send_length = fb_clamped;
      end else if (data_ok) begin
        result.send_kind    = SEND_ACK;
        result.send_block   = exp_r;
        result.commit_bytes = payload;
      end
    end

    case (mode_nxt)
      MODE_READ, MODE_WRITE: result.session_status = ST_ACTIVE;
      MODE_DONE:             result.session_status = ST_FINISHED;
      MODE_FAIL:             result.session_status = ST_FAILED;
      default:               result.session_status = ST_IDLE;
    endcase
    result.failure_reason = (mode_nxt == MODE_FAIL) ? reason_nxt : RSN_NONE;
    result.peer_error     = (mode_nxt == MODE_FAIL) ? peer_nxt : '0;
    result.bytes_done     = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      exp_r    <= BLK_W'(1);
      blen_r   <= '0;
      retry_r  <= '0;
      total_r  <= '0;
      reason_r <= RSN_NONE;
      peer_r   <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      exp_r    <= exp_nxt;
      blen_r   <= blen_nxt;
      retry_r  <= retry_nxt;
      total_r  <= total_nxt;
      reason_r <= reason_nxt;
      peer_r   <= peer_nxt;
    end
  end

endmodule

// ===== design/tftp_transfer_session.sv =====
// ----------------------------------------------------------------------------
// tftp_transfer_session
// Lock-step TFTP transfer engine for one session (read or write transfer).
// ----------------------------------------------------------------------------
// Each accepted event (start read, start write, timeout tick, received packet)
// yields exactly one result: the event is captured in an input register, the
// session step runs in one combinational pass that also updates the session
// state, and the result lands in an output register. One event per cycle is
// sustained while out_tready stays high; a stalled result holds the output
// register and the input register keeps taking one more transfer before
// in_tready drops. max_retransmits is loaded from cfg_wr_data whenever
// cfg_wr_en is high (reset value 2) and should only change while no event is
// in flight. Block numbers wrap at 65536, bytes_done wraps at 2^32.
// ----------------------------------------------------------------------------
module tftp_transfer_session (
  input  logic        clk,
  input  logic        rst_n,
  // input events
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] packet_length, [25:10] packet_opcode, [41:26] packet_block,
  // [51:42] file_bytes, [55:52] zero
  input  logic [55:0] in_tdata,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] send_block, [25:16] send_length, [35:26] commit_bytes,
  // [37:36] session_status, [40:38] failure_reason, [44:41] peer_error,
  // [76:45] bytes_done, [79:77] zero
  output logic [79:0] out_tdata,
  // [1:0] send_kind
  output logic [1:0]  out_tuser,
  // configuration: max_retransmits
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import tts_pkg::*;

`include "tftp_transfer_session_assert.svh"

  logic               s1_valid_r, s1_valid_nxt;
  in_item_t           s1_item_r;
  in_item_t           in_item;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;
  out_item_t          step_result;
  logic [RETX_W-1:0]  max_retx_r;
  logic               in_xfer;
  logic               s2_ready;
  logic               step_en;

  // unpack the incoming transfer
  always_comb begin
    in_item.func          = func_t'(in_tuser);
    in_item.packet_length = in_tdata[9:0];
    in_item.packet_opcode = in_tdata[25:10];
    in_item.packet_block  = in_tdata[41:26];
    in_item.file_bytes    = in_tdata[51:42];
  end

  // handshake: result register frees up when empty or being taken
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_xfer   = in_tvalid && in_tready;
  assign step_en   = s1_valid_r && s2_ready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_retx_r  <= MAX_RETX_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_retx_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  // session state and event step
  tts_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (s1_item_r),
    .max_retx (max_retx_r),
    .result   (step_result)
  );

  // pack the result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.send_kind;
  assign out_tdata  = {3'b000,
                       out_item_r.bytes_done,
                       out_item_r.peer_error,
                       out_item_r.failure_reason,
                       out_item_r.session_status,
                       out_item_r.commit_bytes,
                       out_item_r.send_length,
                       out_item_r.send_block};

  // a failure reason is reported exactly when the session is failed
  `TTS_ASSERT_NOW(a_reason_iff_failed, out_valid_r, ((out_item_r.session_status == ST_FAILED) == (out_item_r.failure_reason != RSN_NONE)))
  // nothing sent means no block number and no length
  `TTS_ASSERT_NOW(a_idle_send_clean, out_valid_r && (out_item_r.send_kind == SEND_NONE), (out_item_r.send_block == '0) && (out_item_r.send_length == '0))
  // committed payload always goes out with an ACK
  `TTS_ASSERT_NOW(a_commit_with_ack, out_valid_r && (out_item_r.commit_bytes != '0), out_item_r.send_kind == SEND_ACK)
  // input stalls only when both registers hold items and the result is stuck
  `TTS_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r && !out_tready)

endmodule
